### rtl/core/assert_macros.svh
// assertion macros for the rtl modules, used by rvm_div
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rvm_pkg.sv
// shared types, constants and command codes of the resampling voice mixer
`timescale 1ns / 1ps
`default_nettype none

package rvm_pkg;

    // default parameter values
    localparam int STORE_DEPTH_DEF   = 16384;
    localparam int FRACTION_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOPING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VOLUME = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 3'd7;

    // register reset values
    localparam logic [1:0]  RST_CHANNEL_COUNT = 2'd1;
    localparam logic [14:0] RST_FRAME_COUNT   = 15'd1;
    localparam logic [23:0] RST_RATE_STEP     = 24'h010000;
    localparam logic [15:0] RST_VOLUME        = 16'h8000;
    localparam logic [1:0]  STEREO_CODE       = 2'd2;

    // datapath widths
    localparam int PINT_W     = 17;   // integer part of the playhead
    localparam int ADDR_EXT_W = 21;   // store address before wrapping
    localparam int MUL_A_W    = 27;
    localparam int MUL_B_W    = 33;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int S_W        = 27;   // interpolated sample, 8 fraction bits
    localparam int CONT_SHIFT = 38;
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 24;
    localparam int DIV_CNT_W  = 6;

    // datapath command codes
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE      = 5'd0;
    localparam t_op OP_RD_BASE   = 5'd1;
    localparam t_op OP_RD_NEXT   = 5'd2;
    localparam t_op OP_RD_B1     = 5'd3;
    localparam t_op OP_RD_N1     = 5'd4;
    localparam t_op OP_CAP_BR    = 5'd5;
    localparam t_op OP_CAP_BL    = 5'd6;
    localparam t_op OP_MUL_IL    = 5'd7;
    localparam t_op OP_SET_SL    = 5'd8;
    localparam t_op OP_MUL_IR    = 5'd9;
    localparam t_op OP_SET_SR    = 5'd10;
    localparam t_op OP_FADE_ZERO = 5'd11;
    localparam t_op OP_MUL_DE    = 5'd12;
    localparam t_op OP_DIV_DE    = 5'd13;
    localparam t_op OP_FADE_UPD  = 5'd14;
    localparam t_op OP_MUL_VG    = 5'd15;
    localparam t_op OP_SET_VG    = 5'd16;
    localparam t_op OP_MUL_CL    = 5'd17;
    localparam t_op OP_SET_CL    = 5'd18;
    localparam t_op OP_MUL_CR    = 5'd19;
    localparam t_op OP_SET_CR    = 5'd20;
    localparam t_op OP_ADV       = 5'd21;
    localparam t_op OP_STOP      = 5'd22;
    localparam t_op OP_DIV_MOD   = 5'd23;
    localparam t_op OP_SET_MOD   = 5'd24;
    localparam t_op OP_OUT       = 5'd25;

    // controller to datapath
    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic playing;
        logic in_range;
        logic stereo;
        logic running;
        logic flen_zero;
        logic looping;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/core/rvm_div.sv
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rvm_div
    import rvm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [DIV_NUM_W-1:0]      o_quo,
    output logic [DIV_DEN_W-1:0]      o_rem
);

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem, r_den;
    logic [DIV_DEN_W:0]   rem_sh, rem_sub;
    logic                 ge;

    // trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider started while busy")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider did not start")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while still dividing")

endmodule

`default_nettype wire

### rtl/core/rvm_datapath.sv
// sample store, voice state, shared multiplier and output register
`timescale 1ns / 1ps
`default_nettype none

module rvm_datapath
    import rvm_pkg::*;
#(
    parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_kind,
    input  wire logic [13:0]           i_sample_addr,
    input  wire logic signed [15:0]    i_sample_value,
    input  wire logic signed [15:0]    i_mix_left,
    input  wire logic signed [15:0]    i_mix_right,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic signed [15:0]         o_left_out,
    output logic signed [15:0]         o_right_out,
    output logic                       o_voice_active
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int POS_W  = PINT_W + FRACTION_BITS;
    localparam int SHIFT  = FRACTION_BITS - 8;
    localparam logic [PROD_W-1:0] INTERP_RND = (PROD_W'(1) << SHIFT) - PROD_W'(1);
    localparam logic [PROD_W-1:0] CONT_RND   = (PROD_W'(1) << CONT_SHIFT) - PROD_W'(1);

    // configuration registers
    logic [1:0]  r_chan;
    logic [14:0] r_fcount;
    logic [23:0] r_step;
    logic        r_loop;
    logic [15:0] r_gain, r_vstart, r_vtarget;
    logic [23:0] r_flen;

    // voice state
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_vol;
    logic [23:0]      r_elapsed;
    logic             r_running, r_playing;

    // working registers
    logic signed [15:0]       r_q, r_al, r_bl, r_ar, r_br;
    logic signed [S_W-1:0]    r_sl, r_sr;
    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]              r_vg;
    logic signed [15:0]       r_cl, r_cr, r_mixl, r_mixr;
    logic                     r_out_valid;
    logic signed [15:0]       r_left, r_right;
    logic                     r_active;

    logic [15:0] mem [STORE_DEPTH];

    // playhead decode
    logic [14:0]            fc, fc_m1;
    logic [PINT_W-1:0]      pos_int;
    logic [FRACTION_BITS-1:0] frac, t_eff;
    logic                   stereo, in_range, last;
    logic [ADDR_EXT_W-1:0]  base, next, step_ch, rd_ext, wr_ext;
    logic                   rd_en, wr_en;

    always_comb begin
        fc       = (r_fcount == '0) ? 15'd1 : r_fcount;
        fc_m1    = fc - 15'd1;
        pos_int  = r_pos[POS_W-1:FRACTION_BITS];
        frac     = r_pos[FRACTION_BITS-1:0];
        stereo   = r_chan == STEREO_CODE;
        in_range = pos_int < PINT_W'(fc);
        last     = !(pos_int < PINT_W'(fc_m1));
        t_eff    = last ? '0 : frac;
        base     = stereo ? ADDR_EXT_W'({pos_int, 1'b0}) : ADDR_EXT_W'(pos_int);
        step_ch  = stereo ? ADDR_EXT_W'(2) : ADDR_EXT_W'(1);
        next     = last ? base : base + step_ch;
        wr_ext   = ADDR_EXT_W'(i_sample_addr);
        wr_en    = i_cmd.accept && !i_kind;
    end

    // store read address
    always_comb begin
        rd_en  = 1'b1;
        unique case (i_cmd.op)
            OP_RD_BASE: rd_ext = base;
            OP_RD_NEXT: rd_ext = next;
            OP_RD_B1:   rd_ext = base + ADDR_EXT_W'(1);
            OP_RD_N1:   rd_ext = next + ADDR_EXT_W'(1);
            default: begin
                rd_ext = base;
                rd_en  = 1'b0;
            end
        endcase
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_ext[ADDR_W-1:0]] <= i_sample_value;
        end
        if (rd_en) begin
            r_q <= mem[rd_ext[ADDR_W-1:0]];
        end
    end

    // fade arithmetic
    logic signed [16:0] d;
    logic               d_neg;
    logic [16:0]        d_abs;
    logic [23:0]        e;
    logic               fade_done;
    logic [15:0]        fade_vol;
    logic               div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den, div_rem;

    always_comb begin
        d         = {1'b0, r_vtarget} - {1'b0, r_vstart};
        d_neg     = d[16];
        d_abs     = d_neg ? -d : d;
        e         = (r_elapsed < r_flen) ? r_elapsed : r_flen;
        fade_done = ({1'b0, r_elapsed} + 25'd1) > {1'b0, r_flen};
        fade_vol  = d_neg ? r_vstart - div_quo[15:0] : r_vstart + div_quo[15:0];
        div_start = (i_cmd.op == OP_DIV_DE) || (i_cmd.op == OP_DIV_MOD);
        if (i_cmd.op == OP_DIV_MOD) begin
            div_num = DIV_NUM_W'(pos_int);
            div_den = DIV_DEN_W'(fc);
        end else begin
            div_num = r_prod[DIV_NUM_W-1:0];
            div_den = r_flen;
        end
    end

    rvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // shared multiplier operands
    logic signed [16:0]        diff_l, diff_r;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_en;

    always_comb begin
        diff_l = {r_bl[15], r_bl} - {r_al[15], r_al};
        diff_r = {r_br[15], r_br} - {r_ar[15], r_ar};
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_MUL_IL: begin
                mul_a = MUL_A_W'(diff_l);
                mul_b = $signed(MUL_B_W'(t_eff));
            end
            OP_MUL_IR: begin
                mul_a = MUL_A_W'(diff_r);
                mul_b = $signed(MUL_B_W'(t_eff));
            end
            OP_MUL_DE: begin
                mul_a = $signed(MUL_A_W'(d_abs));
                mul_b = $signed(MUL_B_W'(e));
            end
            OP_MUL_VG: begin
                mul_a = $signed(MUL_A_W'(r_vol));
                mul_b = $signed(MUL_B_W'(r_gain));
            end
            OP_MUL_CL: begin
                mul_a = r_sl;
                mul_b = $signed(MUL_B_W'(r_vg));
            end
            OP_MUL_CR: begin
                mul_a = r_sr;
                mul_b = $signed(MUL_B_W'(r_vg));
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // truncating scale of the product, toward zero
    logic signed [PROD_W-1:0] interp_adj, interp_q, cont_adj, cont_q;
    logic signed [15:0]       a_sel;
    logic signed [S_W-1:0]    s_val;

    always_comb begin
        interp_adj = r_prod + (r_prod[PROD_W-1] ? $signed(INTERP_RND) : '0);
        interp_q   = interp_adj >>> SHIFT;
        a_sel      = (i_cmd.op == OP_SET_SR) ? r_ar : r_al;
        s_val      = (S_W'(a_sel) <<< 8) + $signed(interp_q[S_W-1:0]);
        cont_adj   = r_prod + (r_prod[PROD_W-1] ? $signed(CONT_RND) : '0);
        cont_q     = cont_adj >>> CONT_SHIFT;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_kind) begin
            r_mixl <= i_mix_left;
            r_mixr <= i_mix_right;
            r_cl   <= '0;
            r_cr   <= '0;
        end
        unique case (i_cmd.op)
            OP_RD_NEXT: r_al <= r_q;
            OP_RD_B1:   r_bl <= r_q;
            OP_RD_N1:   r_ar <= r_q;
            OP_CAP_BR:  r_br <= r_q;
            OP_CAP_BL:  r_bl <= r_q;
            OP_SET_SL: begin
                r_sl <= s_val;
                if (!stereo) begin
                    r_sr <= s_val;
                end
            end
            OP_SET_SR:  r_sr <= s_val;
            OP_SET_VG:  r_vg <= r_prod[31:0];
            OP_SET_CL:  r_cl <= cont_q[15:0];
            OP_SET_CR:  r_cr <= cont_q[15:0];
            OP_OUT: begin
                r_left   <= r_mixl + r_cl;
                r_right  <= r_mixr + r_cr;
                r_active <= r_playing;
            end
            default: ;
        endcase
    end

    // configuration and voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan    <= RST_CHANNEL_COUNT;
            r_fcount  <= RST_FRAME_COUNT;
            r_step    <= RST_RATE_STEP;
            r_loop    <= 1'b0;
            r_gain    <= RST_VOLUME;
            r_vstart  <= RST_VOLUME;
            r_vtarget <= RST_VOLUME;
            r_flen    <= '0;
            r_pos     <= '0;
            r_vol     <= RST_VOLUME;
            r_elapsed <= '0;
            r_running <= 1'b0;
            r_playing <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_chan    <= i_cfg_data[1:0];
                REG_FRAME_COUNT:   r_fcount  <= i_cfg_data[14:0];
                REG_RATE_STEP:     r_step    <= i_cfg_data;
                REG_LOOPING:       r_loop    <= i_cfg_data[0];
                REG_OUTPUT_GAIN:   r_gain    <= i_cfg_data[15:0];
                REG_START_VOLUME: begin
                    r_vstart <= i_cfg_data[15:0];
                    r_vol    <= i_cfg_data[15:0];
                end
                REG_TARGET_VOLUME: r_vtarget <= i_cfg_data[15:0];
                REG_FADE_LENGTH: begin
                    r_flen    <= i_cfg_data;
                    r_elapsed <= '0;
                    r_vol     <= r_vstart;
                    r_running <= i_cfg_data != '0;
                end
                default: ;
            endcase
        end else begin
            unique case (i_cmd.op)
                OP_FADE_ZERO: begin
                    r_vol     <= r_vtarget;
                    r_running <= 1'b0;
                    r_playing <= r_vtarget != '0;
                end
                OP_FADE_UPD: begin
                    if (fade_done) begin
                        r_vol     <= r_vtarget;
                        r_running <= 1'b0;
                        r_playing <= r_vtarget != '0;
                    end else begin
                        r_vol     <= fade_vol;
                        r_elapsed <= r_elapsed + 24'd1;
                    end
                end
                OP_ADV:     r_pos <= r_pos + POS_W'(r_step);
                OP_STOP: begin
                    r_playing <= 1'b0;
                    r_pos     <= '0;
                end
                OP_SET_MOD: r_pos <= {div_rem[PINT_W-1:0], frac};
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.playing   = r_playing;
        o_sts.in_range  = in_range;
        o_sts.stereo    = stereo;
        o_sts.running   = r_running;
        o_sts.flen_zero = r_flen == '0;
        o_sts.looping   = r_loop;
        o_sts.div_done  = div_done;
        o_sts.out_free  = !r_out_valid || !i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_left_out     = r_left;
    assign o_right_out    = r_right;
    assign o_voice_active = r_active;

endmodule

`default_nettype wire

### rtl/core/rvm_ctrl.sv
// sequencer that steps the datapath through one frame word
`timescale 1ns / 1ps
`default_nettype none

module rvm_ctrl
    import rvm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_kind,
    input  wire t_sts i_sts,
    output logic      o_stall,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_RD_BASE  = 5'd1;
    localparam logic [4:0] S_RD_NEXT  = 5'd2;
    localparam logic [4:0] S_RD_B1    = 5'd3;
    localparam logic [4:0] S_RD_N1    = 5'd4;
    localparam logic [4:0] S_CAP_BR   = 5'd5;
    localparam logic [4:0] S_CAP_BL   = 5'd6;
    localparam logic [4:0] S_MUL_IL   = 5'd7;
    localparam logic [4:0] S_SET_SL   = 5'd8;
    localparam logic [4:0] S_MUL_IR   = 5'd9;
    localparam logic [4:0] S_SET_SR   = 5'd10;
    localparam logic [4:0] S_FADE     = 5'd11;
    localparam logic [4:0] S_MUL_DE   = 5'd12;
    localparam logic [4:0] S_DIV_DE   = 5'd13;
    localparam logic [4:0] S_WAIT_DE  = 5'd14;
    localparam logic [4:0] S_FADE_UPD = 5'd15;
    localparam logic [4:0] S_MUL_VG   = 5'd16;
    localparam logic [4:0] S_SET_VG   = 5'd17;
    localparam logic [4:0] S_MUL_CL   = 5'd18;
    localparam logic [4:0] S_SET_CL   = 5'd19;
    localparam logic [4:0] S_MUL_CR   = 5'd20;
    localparam logic [4:0] S_SET_CR   = 5'd21;
    localparam logic [4:0] S_ADV      = 5'd22;
    localparam logic [4:0] S_WRAP     = 5'd23;
    localparam logic [4:0] S_DIV_MOD  = 5'd24;
    localparam logic [4:0] S_WAIT_MOD = 5'd25;
    localparam logic [4:0] S_SET_MOD  = 5'd26;
    localparam logic [4:0] S_OUT      = 5'd27;

    logic [4:0] r_state, n_state;
    logic       accept;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = r_state != S_IDLE;

    // next state and command
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = accept;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_kind) begin
                    if (!i_sts.playing) begin
                        n_state = S_OUT;
                    end else if (i_sts.in_range) begin
                        n_state = S_RD_BASE;
                    end else begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_RD_BASE: begin
                o_cmd.op = OP_RD_BASE;
                n_state  = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd.op = OP_RD_NEXT;
                n_state  = i_sts.stereo ? S_RD_B1 : S_CAP_BL;
            end
            S_RD_B1: begin
                o_cmd.op = OP_RD_B1;
                n_state  = S_RD_N1;
            end
            S_RD_N1: begin
                o_cmd.op = OP_RD_N1;
                n_state  = S_CAP_BR;
            end
            S_CAP_BR: begin
                o_cmd.op = OP_CAP_BR;
                n_state  = S_MUL_IL;
            end
            S_CAP_BL: begin
                o_cmd.op = OP_CAP_BL;
                n_state  = S_MUL_IL;
            end
            S_MUL_IL: begin
                o_cmd.op = OP_MUL_IL;
                n_state  = S_SET_SL;
            end
            S_SET_SL: begin
                o_cmd.op = OP_SET_SL;
                n_state  = i_sts.stereo ? S_MUL_IR : S_FADE;
            end
            S_MUL_IR: begin
                o_cmd.op = OP_MUL_IR;
                n_state  = S_SET_SR;
            end
            S_SET_SR: begin
                o_cmd.op = OP_SET_SR;
                n_state  = S_FADE;
            end
            S_FADE: begin
                if (!i_sts.running) begin
                    n_state = S_MUL_VG;
                end else if (i_sts.flen_zero) begin
                    o_cmd.op = OP_FADE_ZERO;
                    n_state  = S_MUL_VG;
                end else begin
                    n_state = S_MUL_DE;
                end
            end
            S_MUL_DE: begin
                o_cmd.op = OP_MUL_DE;
                n_state  = S_DIV_DE;
            end
            S_DIV_DE: begin
                o_cmd.op = OP_DIV_DE;
                n_state  = S_WAIT_DE;
            end
            S_WAIT_DE: begin
                if (i_sts.div_done) begin
                    n_state = S_FADE_UPD;
                end
            end
            S_FADE_UPD: begin
                o_cmd.op = OP_FADE_UPD;
                n_state  = S_MUL_VG;
            end
            S_MUL_VG: begin
                o_cmd.op = OP_MUL_VG;
                n_state  = S_SET_VG;
            end
            S_SET_VG: begin
                o_cmd.op = OP_SET_VG;
                n_state  = S_MUL_CL;
            end
            S_MUL_CL: begin
                o_cmd.op = OP_MUL_CL;
                n_state  = S_SET_CL;
            end
            S_SET_CL: begin
                o_cmd.op = OP_SET_CL;
                n_state  = S_MUL_CR;
            end
            S_MUL_CR: begin
                o_cmd.op = OP_MUL_CR;
                n_state  = S_SET_CR;
            end
            S_SET_CR: begin
                o_cmd.op = OP_SET_CR;
                n_state  = S_ADV;
            end
            S_ADV: begin
                o_cmd.op = OP_ADV;
                n_state  = S_WRAP;
            end
            S_WRAP: begin
                if (i_sts.in_range) begin
                    n_state = S_OUT;
                end else if (i_sts.looping) begin
                    n_state = S_DIV_MOD;
                end else begin
                    o_cmd.op = OP_STOP;
                    n_state  = S_OUT;
                end
            end
            S_DIV_MOD: begin
                o_cmd.op = OP_DIV_MOD;
                n_state  = S_WAIT_MOD;
            end
            S_WAIT_MOD: begin
                if (i_sts.div_done) begin
                    n_state = S_SET_MOD;
                end
            end
            S_SET_MOD: begin
                o_cmd.op = OP_SET_MOD;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/core/resampling_voice_mixer.sv
// Write word: taken while idle, and a new word may follow in the next cycle.
// Frame word: mono or stereo sample reads and interpolation, then the output register,
// plus the 40-step serial divider when a fade step runs and when a looping playhead wraps.
// The next word is taken the cycle after the output register loads, later if it stalls.
// Frame words are sequenced through the shared 27x33 multiplier and the serial divider.
// Synchronous active-low reset: registers to defaults, voice playing, store undefined.
`timescale 1ns / 1ps
`default_nettype none

module resampling_voice_mixer
    import rvm_pkg::*;
#(
    parameter int STORE_DEPTH   = STORE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_kind,
    input  wire logic [13:0]           i_sample_addr,
    input  wire logic signed [15:0]    i_sample_value,
    input  wire logic signed [15:0]    i_mix_left,
    input  wire logic signed [15:0]    i_mix_right,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [15:0]         o_left_out,
    output logic signed [15:0]         o_right_out,
    output logic                       o_voice_active,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    rvm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    rvm_datapath #(
        .STORE_DEPTH   (STORE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_sample_addr  (i_sample_addr),
        .i_sample_value (i_sample_value),
        .i_mix_left     (i_mix_left),
        .i_mix_right    (i_mix_right),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_voice_active (o_voice_active)
    );

endmodule

`default_nettype wire
